// ===== src/mtc_pkg.sv =====
// Package for the MIDI time code decoder: item structs, message constants
// and the per-rate reciprocal constants for the frames term. No dependencies.
`timescale 1ns / 1ps

package mtc_pkg;

  localparam int MS_W    = 27;  // widest frame time in ms fits 27 bits
  localparam int FRAC_W  = 13;

  // floor(f * 1000 / fps) = (f * FRAC_MUL_x) >> FRAC_SHIFT for f below 128;
  // 29.97 uses 100000 / 2997
  localparam int FRAC_SHIFT  = 20;
  localparam int FRAC_MUL_W  = 26;
  localparam int FRAC_PROD_W = 33;

  localparam logic [FRAC_MUL_W-1:0] FRAC_MUL_24   = 26'd43690667;
  localparam logic [FRAC_MUL_W-1:0] FRAC_MUL_25   = 26'd41943040;
  localparam logic [FRAC_MUL_W-1:0] FRAC_MUL_2997 = 26'd34987521;
  localparam logic [FRAC_MUL_W-1:0] FRAC_MUL_30   = 26'd34952534;

  localparam logic [1:0] RC_24   = 2'd0;
  localparam logic [1:0] RC_25   = 2'd1;
  localparam logic [1:0] RC_2997 = 2'd2;
  localparam logic [1:0] RC_30   = 2'd3;

  localparam logic [7:0] ST_QUARTER = 8'hF1;
  localparam logic [7:0] ST_SYSEX   = 8'hF0;
  localparam logic [7:0] ST_EOX     = 8'hF7;
  localparam logic [7:0] SX_RT_ID   = 8'h7F;
  localparam logic [7:0] SX_MTC_ID  = 8'h01;
  localparam logic [3:0] FULL_LEN   = 4'd10;
  localparam logic [3:0] QUARTERS   = 4'd8;
  localparam logic [1:0] RATE_RESET = 2'd1;

  localparam logic [4:0] MS_QUARTER_SLOW = 5'd10;
  localparam logic [4:0] MS_QUARTER_FAST = 5'd8;

  typedef struct packed {
    logic [3:0] msg_length;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] byte7;
    logic [7:0] byte8;
    logic [7:0] byte9;
  } mtc_msg_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
    logic [6:0] frames;
    logic [1:0] rate;
  } tc_frame_t;

  typedef struct packed {
    logic        recognized;
    logic        position_loaded;
    logic [31:0] head_ms;
    tc_frame_t   frame;
  } mtc_result_t;

endpackage

// ===== src/mtc_msg_if.sv =====
// Input channel: one MIDI message per beat with valid/ready.
// Standalone, no package dependency.
`timescale 1ns / 1ps

interface mtc_msg_if;
  logic       valid;
  logic       ready;
  logic [3:0] msg_length;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;
  logic [7:0] byte6;
  logic [7:0] byte7;
  logic [7:0] byte8;
  logic [7:0] byte9;

  modport source (output valid, msg_length, byte0, byte1, byte2, byte3, byte4,
                  byte5, byte6, byte7, byte8, byte9, input ready);
  modport sink (input valid, msg_length, byte0, byte1, byte2, byte3, byte4,
                byte5, byte6, byte7, byte8, byte9, output ready);
endinterface

// ===== src/mtc_tc_if.sv =====
// Output channel: decoded time code per beat with valid/ready.
// Standalone, no package dependency.
`timescale 1ns / 1ps

interface mtc_tc_if;
  logic        valid;
  logic        ready;
  logic        recognized;
  logic        position_loaded;
  logic [31:0] head_ms;
  logic [4:0]  cur_hours;
  logic [6:0]  cur_minutes;
  logic [6:0]  cur_seconds;
  logic [6:0]  cur_frames;
  logic [1:0]  cur_rate;

  modport source (output valid, recognized, position_loaded, head_ms, cur_hours,
                  cur_minutes, cur_seconds, cur_frames, cur_rate, input ready);
  modport sink (input valid, recognized, position_loaded, head_ms, cur_hours,
                cur_minutes, cur_seconds, cur_frames, cur_rate, output ready);
endinterface

// ===== src/mtc_frame_ms.sv =====
// Converts an hh:mm:ss:ff time code frame to milliseconds.
// Depends on mtc_pkg (frame struct, per-rate reciprocal constants).
`timescale 1ns / 1ps

module mtc_frame_ms
  import mtc_pkg::*;
(
  input  tc_frame_t        frame,
  output logic [MS_W-1:0]  ms
);

  logic [FRAC_MUL_W-1:0]  frac_mul;
  logic [FRAC_PROD_W-1:0] frac_prod;
  logic [FRAC_W-1:0]      frac;

  always_comb begin
    unique case (frame.rate)
      RC_24:   frac_mul = FRAC_MUL_24;
      RC_25:   frac_mul = FRAC_MUL_25;
      RC_2997: frac_mul = FRAC_MUL_2997;
      RC_30:   frac_mul = FRAC_MUL_30;
    endcase
  end

  assign frac_prod = FRAC_PROD_W'(frame.frames) * FRAC_PROD_W'(frac_mul);
  assign frac = frac_prod[FRAC_SHIFT +: FRAC_W];

  assign ms = MS_W'(frame.hours)   * MS_W'(3600000)
            + MS_W'(frame.minutes) * MS_W'(60000)
            + MS_W'(frame.seconds) * MS_W'(1000)
            + MS_W'(frac);

endmodule

// ===== src/mtc_core.sv =====
// Decoder state and next-state logic: quarter-frame assembly, full-frame
// load and head tracking. Depends on mtc_pkg and mtc_frame_ms.
`timescale 1ns / 1ps

module mtc_core
  import mtc_pkg::*;
#(
  parameter int HEAD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  mtc_msg_t    msg,
  output mtc_result_t res
);

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    QF_FRAME_LO = 3'd0,
    QF_FRAME_HI = 3'd1,
    QF_SEC_LO   = 3'd2,
    QF_SEC_HI   = 3'd3,
    QF_MIN_LO   = 3'd4,
    QF_MIN_HI   = 3'd5,
    QF_HOUR_LO  = 3'd6,
    QF_HOUR_HI  = 3'd7
  } qf_kind_t;

  localparam int HX_W = (HEAD_WIDTH > 32) ? HEAD_WIDTH : 32;

  logic [7:0]            last_data, last_data_next;
  dir_t                  order_dir, order_dir_next;
  logic [3:0]            quarter_count, quarter_count_next;
  logic                  first_seen, first_seen_next;
  logic                  last_seen, last_seen_next;
  logic [4:0]            asm_frames, asm_frames_next;
  logic [5:0]            asm_seconds, asm_seconds_next;
  logic [5:0]            asm_minutes, asm_minutes_next;
  logic [4:0]            asm_hours, asm_hours_next;
  logic [1:0]            asm_rate, asm_rate_next;
  tc_frame_t             frame_now, frame_now_next;
  logic [HEAD_WIDTH-1:0] head_pos, head_pos_next, head_adv;

  logic                  is_quarter, is_full, loaded;
  logic [3:0]            kind;
  logic [MS_W-1:0]       load_ms;
  logic [HX_W-1:0]       head_ext;

  assign kind = msg.byte1[7:4];
  assign is_quarter = (msg.byte0 == ST_QUARTER);
  assign is_full = (msg.byte0 == ST_SYSEX) && (msg.msg_length == FULL_LEN) &&
                   (msg.byte1 == SX_RT_ID) && (msg.byte2 == SX_RT_ID) &&
                   (msg.byte3 == SX_MTC_ID) && (msg.byte4 == SX_MTC_ID) &&
                   (msg.byte9 == ST_EOX);

  always_comb begin
    last_data_next     = last_data;
    order_dir_next     = order_dir;
    quarter_count_next = quarter_count;
    first_seen_next    = first_seen;
    last_seen_next     = last_seen;
    asm_frames_next    = asm_frames;
    asm_seconds_next   = asm_seconds;
    asm_minutes_next   = asm_minutes;
    asm_hours_next     = asm_hours;
    asm_rate_next      = asm_rate;
    frame_now_next     = frame_now;
    loaded             = 1'b0;
    head_adv           = head_pos;

    if (is_quarter) begin
      if (order_dir == DIR_NONE && quarter_count > 4'd1) begin
        if (last_data[7:4] < kind) begin
          order_dir_next = DIR_FWD;
        end else if (last_data[7:4] > kind) begin
          order_dir_next = DIR_BACK;
        end
      end
      head_adv = head_pos + HEAD_WIDTH'(frame_now.rate[1] ? MS_QUARTER_FAST
                                                           : MS_QUARTER_SLOW);
      last_data_next = msg.byte1;
      if (!kind[3]) begin
        unique case (qf_kind_t'(kind[2:0]))
          QF_FRAME_LO: begin
            asm_frames_next = {1'b0, msg.byte1[3:0]};
            first_seen_next = 1'b1;
          end
          QF_FRAME_HI: asm_frames_next  = asm_frames | {msg.byte1[0], 4'b0};
          QF_SEC_LO:   asm_seconds_next = {2'b0, msg.byte1[3:0]};
          QF_SEC_HI:   asm_seconds_next = asm_seconds | {msg.byte1[1:0], 4'b0};
          QF_MIN_LO:   asm_minutes_next = {2'b0, msg.byte1[3:0]};
          QF_MIN_HI:   asm_minutes_next = asm_minutes | {msg.byte1[1:0], 4'b0};
          QF_HOUR_LO:  asm_hours_next   = {1'b0, msg.byte1[3:0]};
          QF_HOUR_HI: begin
            asm_hours_next = asm_hours | {msg.byte1[0], 4'b0};
            asm_rate_next  = msg.byte1[2:1];
            last_seen_next = 1'b1;
          end
          default: ;
        endcase
        if (quarter_count < QUARTERS) begin
          quarter_count_next = quarter_count + 4'd1;
        end
        loaded = (quarter_count_next >= QUARTERS) &&
                 (((kind[2:0] == QF_FRAME_LO) && order_dir_next == DIR_BACK &&
                   last_seen_next) ||
                  ((kind[2:0] == QF_HOUR_HI) && order_dir_next == DIR_FWD &&
                   first_seen_next));
      end
      if (loaded) begin
        frame_now_next.hours   = asm_hours_next;
        frame_now_next.minutes = {1'b0, asm_minutes_next};
        frame_now_next.seconds = {1'b0, asm_seconds_next};
        frame_now_next.frames  = 7'(asm_frames_next) + 7'd2;
        frame_now_next.rate    = asm_rate_next;
        asm_frames_next    = '0;
        asm_seconds_next   = '0;
        asm_minutes_next   = '0;
        asm_hours_next     = '0;
        asm_rate_next      = RATE_RESET;
        order_dir_next     = DIR_NONE;
        quarter_count_next = '0;
        first_seen_next    = 1'b0;
        last_seen_next     = 1'b0;
      end
    end else if (is_full) begin
      loaded = 1'b1;
      frame_now_next.hours   = msg.byte5[4:0];
      frame_now_next.rate    = msg.byte5[6:5];
      frame_now_next.minutes = msg.byte6[6:0];
      frame_now_next.seconds = msg.byte7[6:0];
      frame_now_next.frames  = msg.byte8[6:0];
    end
  end

  mtc_frame_ms u_frame_ms (
    .frame (frame_now_next),
    .ms    (load_ms)
  );

  assign head_pos_next = loaded ? HEAD_WIDTH'(load_ms) : head_adv;
  assign head_ext = HX_W'(head_pos_next);

  assign res.recognized      = is_quarter || is_full;
  assign res.position_loaded = loaded;
  assign res.head_ms         = head_ext[31:0];
  assign res.frame           = frame_now_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_data     <= '0;
      order_dir     <= DIR_NONE;
      quarter_count <= '0;
      first_seen    <= 1'b0;
      last_seen     <= 1'b0;
      asm_frames    <= '0;
      asm_seconds   <= '0;
      asm_minutes   <= '0;
      asm_hours     <= '0;
      asm_rate      <= RATE_RESET;
      frame_now     <= '{hours: '0, minutes: '0, seconds: '0, frames: '0,
                         rate: RATE_RESET};
      head_pos      <= '0;
    end else if (step) begin
      last_data     <= last_data_next;
      order_dir     <= order_dir_next;
      quarter_count <= quarter_count_next;
      first_seen    <= first_seen_next;
      last_seen     <= last_seen_next;
      asm_frames    <= asm_frames_next;
      asm_seconds   <= asm_seconds_next;
      asm_minutes   <= asm_minutes_next;
      asm_hours     <= asm_hours_next;
      asm_rate      <= asm_rate_next;
      frame_now     <= frame_now_next;
      head_pos      <= head_pos_next;
    end
  end

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    quarter_count <= QUARTERS)
    else $error("quarter count above saturation");

  a_qf_clear: assert property (@(posedge clk) disable iff (rst)
    step && is_quarter && loaded |=> quarter_count == '0 && order_dir == DIR_NONE)
    else $error("assembly not cleared after quarter-frame load");

  a_other_hold: assert property (@(posedge clk) disable iff (rst)
    step && !is_quarter && !is_full |=> $stable(head_pos) && $stable(frame_now))
    else $error("unrecognized message changed state");

  a_full_keeps_asm: assert property (@(posedge clk) disable iff (rst)
    step && is_full |=> $stable(quarter_count) && $stable(last_data))
    else $error("full frame disturbed quarter-frame assembly");

endmodule

// ===== src/midi_timecode_decoder.sv =====
// MIDI time code decoder. A message beat is registered in the input register and
// then processed by mtc_core into the result register, from which its result beat
// is offered; a stalled output can hold it in the input register between the two.
// Throughput: one message per cycle while tc_out is not stalled. While a result
// waits, the input register takes one more beat and then holds msg_in.ready low.
// Reset (rst, synchronous): empties both registers, clears time and head, rate 25 fps.
`timescale 1ns / 1ps

module midi_timecode_decoder
  import mtc_pkg::*;
#(
  parameter int HEAD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  mtc_msg_if.sink  msg_in,
  mtc_tc_if.source tc_out
);

  mtc_msg_t    item;
  logic        item_valid;
  mtc_result_t res_next, res;
  logic        out_valid;
  logic        advance, step;

  assign advance = !out_valid || tc_out.ready;
  assign step = item_valid && advance;
  assign msg_in.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (msg_in.ready) begin
        item_valid <= msg_in.valid;
      end
      if (advance) begin
        out_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg_in.valid && msg_in.ready) begin
      item <= '{msg_length: msg_in.msg_length, byte0: msg_in.byte0,
                byte1: msg_in.byte1, byte2: msg_in.byte2, byte3: msg_in.byte3,
                byte4: msg_in.byte4, byte5: msg_in.byte5, byte6: msg_in.byte6,
                byte7: msg_in.byte7, byte8: msg_in.byte8, byte9: msg_in.byte9};
    end
    if (step) begin
      res <= res_next;
    end
  end

  mtc_core #(
    .HEAD_WIDTH (HEAD_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .msg  (item),
    .res  (res_next)
  );

  assign tc_out.valid           = out_valid;
  assign tc_out.recognized      = res.recognized;
  assign tc_out.position_loaded = res.position_loaded;
  assign tc_out.head_ms         = res.head_ms;
  assign tc_out.cur_hours       = res.frame.hours;
  assign tc_out.cur_minutes     = res.frame.minutes;
  assign tc_out.cur_seconds     = res.frame.seconds;
  assign tc_out.cur_frames      = res.frame.frames;
  assign tc_out.cur_rate        = res.frame.rate;

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    item_valid && out_valid && !tc_out.ready |-> !msg_in.ready)
    else $error("input taken while pipeline blocked");

  a_step_fills: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("processed beat did not reach output register");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !item_valid && advance |=> !out_valid)
    else $error("result invented without input");

endmodule

// ===== tb/tb.sv =====
// Testbench for midi_timecode_decoder: quarter-frame runs, full-frame sysex and noise
// are sent, and every result beat is checked against a timecode tracker in the class below.
// Depends on mtc_pkg, mtc_msg_if, mtc_tc_if and midi_timecode_decoder.
`timescale 1ns / 1ps

module tb;
  import mtc_pkg::*;

  typedef enum logic [1:0] {DIR_UNKNOWN, DIR_FWD, DIR_BACK} order_e;
  typedef enum logic [1:0] {RATE_24, RATE_25, RATE_2997, RATE_30} rate_e;
  typedef enum logic [3:0] {
    QF_FRAME_LO, QF_FRAME_HI, QF_SEC_LO, QF_SEC_HI,
    QF_MIN_LO, QF_MIN_HI, QF_HOUR_LO, QF_HOUR_RATE
  } qf_kind_e;

  localparam logic [7:0] ST_NOTE_ON = 8'h90;
  localparam logic [3:0] QF_LEN     = 4'd2;
  localparam int         NUM_MSGS   = 1675;

  class tc_scoreboard;
    logic [7:0]  last_data;
    order_e      order_dir;
    logic [3:0]  quarter_count;
    bit          first_seen, last_seen;
    logic [4:0]  asm_frames, asm_hours;
    logic [5:0]  asm_seconds, asm_minutes;
    logic [1:0]  asm_rate;
    tc_frame_t   now_frame;
    logic [31:0] head;
    mtc_result_t pending_timecodes[$];
    int          fail_count;

    function new();
      last_data = '0;
      clear_assembly();
      now_frame = '0;
      now_frame.rate = RATE_25;
      head = '0;
      fail_count = 0;
    endfunction

    function void clear_assembly();
      asm_frames = '0;
      asm_seconds = '0;
      asm_minutes = '0;
      asm_hours = '0;
      asm_rate = RATE_25;
      order_dir = DIR_UNKNOWN;
      quarter_count = '0;
      first_seen = 1'b0;
      last_seen = 1'b0;
    endfunction

    function logic [31:0] frame_to_ms();
      longint unsigned ms, hh, mm, ss, fr;
      hh = now_frame.hours;
      mm = now_frame.minutes;
      ss = now_frame.seconds;
      fr = now_frame.frames;
      ms = hh * 3600000 + mm * 60000 + ss * 1000;
      case (now_frame.rate)
        RATE_24:   ms += fr * 1000 / 24;
        RATE_25:   ms += fr * 1000 / 25;
        RATE_2997: ms += fr * 100000 / 2997;
        default:   ms += fr * 1000 / 30;
      endcase
      return ms[31:0];
    endfunction

    function bit decode_quarter(logic [7:0] data);
      logic [3:0] kind;
      bit done;
      kind = data[7:4];
      done = 1'b0;
      if (order_dir == DIR_UNKNOWN && quarter_count > 1) begin
        if (last_data[7:4] < kind) order_dir = DIR_FWD;
        else if (last_data[7:4] > kind) order_dir = DIR_BACK;
      end
      head = head + ((now_frame.rate == RATE_24 || now_frame.rate == RATE_25) ? 10 : 8);
      last_data = data;
      if (kind > QF_HOUR_RATE) return 1'b0;
      case (kind)
        QF_FRAME_LO: begin
          asm_frames = {1'b0, data[3:0]};
          first_seen = 1'b1;
        end
        QF_FRAME_HI: asm_frames = asm_frames | {data[0], 4'b0};
        QF_SEC_LO:   asm_seconds = {2'b0, data[3:0]};
        QF_SEC_HI:   asm_seconds = asm_seconds | {data[1:0], 4'b0};
        QF_MIN_LO:   asm_minutes = {2'b0, data[3:0]};
        QF_MIN_HI:   asm_minutes = asm_minutes | {data[1:0], 4'b0};
        QF_HOUR_LO:  asm_hours = {1'b0, data[3:0]};
        default: begin
          asm_hours = asm_hours | {data[0], 4'b0};
          asm_rate = data[2:1];
          last_seen = 1'b1;
        end
      endcase
      if (quarter_count < QUARTERS) quarter_count++;
      if (kind == QF_FRAME_LO && quarter_count >= QUARTERS && order_dir == DIR_BACK && last_seen)
        done = 1'b1;
      if (kind == QF_HOUR_RATE && quarter_count >= QUARTERS && order_dir == DIR_FWD && first_seen)
        done = 1'b1;
      if (done) begin
        // no carry of the 2-frame adjust into seconds
        now_frame.frames = {2'b0, asm_frames} + 7'd2;
        now_frame.seconds = {1'b0, asm_seconds};
        now_frame.minutes = {1'b0, asm_minutes};
        now_frame.hours = asm_hours;
        now_frame.rate = asm_rate;
        head = frame_to_ms();
        clear_assembly();
      end
      return done;
    endfunction

    function void note_msg(mtc_msg_t m);
      mtc_result_t r;
      r = '0;
      if (m.byte0 == ST_QUARTER) begin
        r.recognized = 1'b1;
        r.position_loaded = decode_quarter(m.byte1);
      end else if (m.byte0 == ST_SYSEX && m.msg_length == FULL_LEN && m.byte1 == SX_RT_ID &&
                   m.byte2 == SX_RT_ID && m.byte3 == SX_MTC_ID && m.byte4 == SX_MTC_ID &&
                   m.byte9 == ST_EOX) begin
        r.recognized = 1'b1;
        r.position_loaded = 1'b1;
        now_frame.hours = m.byte5[4:0];
        now_frame.rate = m.byte5[6:5];
        now_frame.minutes = m.byte6[6:0];
        now_frame.seconds = m.byte7[6:0];
        now_frame.frames = m.byte8[6:0];
        head = frame_to_ms();
      end
      r.head_ms = head;
      r.frame = now_frame;
      pending_timecodes.push_back(r);
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
        fail_count++;
      end
    endfunction

    function void check_timecode(mtc_result_t got);
      mtc_result_t want;
      if (pending_timecodes.size() == 0) begin
        $display("%0t unexpected result beat: expected none, got head %0d",
                 $time, got.head_ms);
        fail_count++;
        return;
      end
      want = pending_timecodes.pop_front();
      compare_field("recognized", want.recognized, got.recognized);
      compare_field("position_loaded", want.position_loaded, got.position_loaded);
      compare_field("head_ms", want.head_ms, got.head_ms);
      compare_field("cur_hours", want.frame.hours, got.frame.hours);
      compare_field("cur_minutes", want.frame.minutes, got.frame.minutes);
      compare_field("cur_seconds", want.frame.seconds, got.frame.seconds);
      compare_field("cur_frames", want.frame.frames, got.frame.frames);
      compare_field("cur_rate", want.frame.rate, got.frame.rate);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  mtc_msg_if msg_bus ();
  mtc_tc_if  tc_bus ();

  midi_timecode_decoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .msg_in (msg_bus),
    .tc_out (tc_bus)
  );

  tc_scoreboard sb;
  int msg_count = 0;
  int hold_len = 0;
  bit src_busy = 1'b1;
  bit snk_busy = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_gap(bit busy);
    return busy ? $urandom_range(0, 7) : 0;
  endfunction

  function automatic mtc_msg_t random_msg();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[83:0];
  endfunction

  function automatic mtc_msg_t quarter_msg(logic [3:0] kind, logic [3:0] nib);
    mtc_msg_t m;
    m = random_msg();
    m.byte0 = ST_QUARTER;
    m.byte1 = {kind, nib};
    if ($urandom_range(0, 3) != 0) m.msg_length = QF_LEN;
    return m;
  endfunction

  function automatic mtc_msg_t full_frame_msg(logic [7:0] rh, logic [7:0] mn,
                                              logic [7:0] sc, logic [7:0] fr);
    mtc_msg_t m;
    m = random_msg();
    m.msg_length = FULL_LEN;
    m.byte0 = ST_SYSEX;
    m.byte1 = SX_RT_ID;
    m.byte2 = SX_RT_ID;
    m.byte3 = SX_MTC_ID;
    m.byte4 = SX_MTC_ID;
    m.byte5 = rh;
    m.byte6 = mn;
    m.byte7 = sc;
    m.byte8 = fr;
    m.byte9 = ST_EOX;
    return m;
  endfunction

  task automatic send_msg(input mtc_msg_t m);
    int gap;
    gap = draw_gap(src_busy);
    repeat (gap) begin
      @(negedge clk);
      msg_bus.valid <= 1'b0;
    end
    @(negedge clk);
    msg_bus.valid <= 1'b1;
    msg_bus.msg_length <= m.msg_length;
    msg_bus.byte0 <= m.byte0;
    msg_bus.byte1 <= m.byte1;
    msg_bus.byte2 <= m.byte2;
    msg_bus.byte3 <= m.byte3;
    msg_bus.byte4 <= m.byte4;
    msg_bus.byte5 <= m.byte5;
    msg_bus.byte6 <= m.byte6;
    msg_bus.byte7 <= m.byte7;
    msg_bus.byte8 <= m.byte8;
    msg_bus.byte9 <= m.byte9;
    do @(posedge clk); while (!msg_bus.ready);
    sb.note_msg(m);
    msg_count++;
  endtask

  // quarter frames walking up (step 1) or down (step -1) from a start type
  task automatic send_run(int start, int step, int len, bit jitter);
    logic [3:0] kind;
    for (int i = 0; i < len; i++) begin
      kind = 4'((start + step * i + 32) & 7);
      if (jitter && $urandom_range(0, 19) == 0) kind = 4'($urandom);
      send_msg(quarter_msg(kind, 4'($urandom)));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    msg_bus.valid <= 1'b0;
    while (sb.pending_timecodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int stall;
    mtc_result_t got;
    tc_bus.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = draw_gap(snk_busy);
      if (hold_len != 0) begin
        stall = hold_len;
        hold_len = 0;
      end
      if (stall != 0) begin
        @(negedge clk);
        tc_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      tc_bus.ready <= 1'b1;
      do @(posedge clk); while (!tc_bus.valid);
      got.recognized = tc_bus.recognized;
      got.position_loaded = tc_bus.position_loaded;
      got.head_ms = tc_bus.head_ms;
      got.frame.hours = tc_bus.cur_hours;
      got.frame.minutes = tc_bus.cur_minutes;
      got.frame.seconds = tc_bus.cur_seconds;
      got.frame.frames = tc_bus.cur_frames;
      got.frame.rate = tc_bus.cur_rate;
      sb.check_timecode(got);
    end
  end

  initial begin
    mtc_msg_t m;
    bit held, paused;
    int pick;
    held = 1'b0;
    paused = 1'b0;
    sb = new();
    msg_bus.valid = 1'b0;
    msg_bus.msg_length = '0;
    msg_bus.byte0 = '0;
    msg_bus.byte1 = '0;
    msg_bus.byte2 = '0;
    msg_bus.byte3 = '0;
    msg_bus.byte4 = '0;
    msg_bus.byte5 = '0;
    msg_bus.byte6 = '0;
    msg_bus.byte7 = '0;
    msg_bus.byte8 = '0;
    msg_bus.byte9 = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: other message, full frames at the extremes, broken full frames,
    // one run each way, unknown quarter type, short quarter frame
    m = random_msg();
    m.byte0 = ST_NOTE_ON;
    send_msg(m);
    send_msg(full_frame_msg(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_msg(full_frame_msg({1'b0, RATE_2997, 5'd0}, 8'd0, 8'd0, 8'd29));
    m = full_frame_msg(8'h00, 8'h01, 8'h02, 8'h03);
    m.msg_length = FULL_LEN - 4'd1;
    send_msg(m);
    m = full_frame_msg(8'h00, 8'h01, 8'h02, 8'h03);
    m.byte9 = ST_EOX ^ 8'h01;
    send_msg(m);
    send_run(QF_FRAME_LO, 1, 8, 1'b0);
    send_run(QF_HOUR_RATE, -1, 8, 1'b0);
    send_msg(quarter_msg(4'hA, 4'h5));
    m = quarter_msg(QF_SEC_LO, 4'hF);
    m.msg_length = '0;
    send_msg(m);
    wait_drained();

    while (msg_count < NUM_MSGS) begin
      if ($urandom_range(0, 39) == 0) begin
        src_busy = $urandom_range(0, 2) != 0;
        snk_busy = $urandom_range(0, 2) != 0;
      end
      if (!held && msg_count > 600) begin
        held = 1'b1;
        hold_len = 48;
      end
      if (!paused && msg_count > 1200) begin
        paused = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 19);
      if (pick <= 10) begin
        send_run($urandom_range(0, 7), $urandom_range(0, 1) ? 1 : -1,
                 $urandom_range(8, 16), 1'b1);
      end else if (pick <= 13) begin
        send_msg(full_frame_msg(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
      end else if (pick <= 15) begin
        m = full_frame_msg(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        case ($urandom_range(0, 6))
          0: m.msg_length ^= 4'($urandom_range(1, 15));
          1: m.byte1 ^= 8'($urandom_range(1, 255));
          2: m.byte2 ^= 8'($urandom_range(1, 255));
          3: m.byte3 ^= 8'($urandom_range(1, 255));
          4: m.byte4 ^= 8'($urandom_range(1, 255));
          5: m.byte9 ^= 8'($urandom_range(1, 255));
          default: m.byte0 ^= 8'($urandom_range(1, 255));
        endcase
        send_msg(m);
      end else if (pick <= 17) begin
        m = random_msg();
        if ($urandom_range(0, 1) == 0) m.byte0 = ST_SYSEX;
        send_msg(m);
      end else begin
        send_msg(quarter_msg(4'($urandom), 4'($urandom)));
      end
    end

    wait_drained();
    if (sb.fail_count == 0 && sb.pending_timecodes.size() == 0) begin
      $display("** midi_timecode_decoder: PASSED **");
    end else begin
      $display("** midi_timecode_decoder: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** midi_timecode_decoder: FAILED **");
    $finish;
  end

endmodule

// ===== midi_timecode_decoder.f =====
src/mtc_pkg.sv
src/mtc_msg_if.sv
src/mtc_tc_if.sv
src/mtc_frame_ms.sv
src/mtc_core.sv
src/midi_timecode_decoder.sv
tb/tb.sv
